// File: rtl/bts_pkg.sv
// shared types and constants of the bilinear texel sampler
`default_nettype none
package bts_pkg;

    // input op codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam int  CFG_IDX_W       = 1;
    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;
    localparam int  DIM_W           = 9;

    // widest store address and fraction the command carries
    localparam int ADDR_MAX_W = 24;
    localparam int FRAC_MAX_W = 12;
    // per-channel accumulator: four taps of 256 x 255
    localparam int ACC_W      = 18;

    typedef struct packed {
        logic        op;
        logic [15:0] texel_addr;
        logic [31:0] texel_data;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic [31:0] sample;
        logic        in_range;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SAMPLE,
        CMD_MISS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [ADDR_MAX_W-1:0] addr;
        logic [31:0]           data;
        logic [FRAC_MAX_W-1:0] fx;
        logic [FRAC_MAX_W-1:0] fy;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TAPS,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

// File: rtl/bts_fifo.sv
// small synchronous queue with full and empty flags
`default_nettype none
module bts_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  T     i_data,
    output logic o_full,
    input  wire  i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/bts_front.sv
// front end: size registers, item classification and base address
`default_nettype none
module bts_front #(
    parameter int TEX_MAX_DIM = 256,
    parameter int FRAC_BITS   = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [bts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [bts_pkg::DIM_W-1:0]         i_cfg_data,
    input  bts_pkg::t_in_item                 i_item,
    input  wire                               i_accept,
    output bts_pkg::t_cmd                     o_cmd,
    output logic                              o_cmd_push,
    output logic [bts_pkg::DIM_W-1:0]         o_width
);
    localparam int DEPTH = TEX_MAX_DIM * TEX_MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = 16 - FRAC_BITS;
    localparam int PW    = IW + bts_pkg::DIM_W + 1;
    localparam int FW    = bts_pkg::FRAC_MAX_W;
    localparam int DW    = bts_pkg::DIM_W;
    localparam int XW    = bts_pkg::ADDR_MAX_W;

    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;
    logic [IW-1:0] ix;
    logic [IW-1:0] iy;
    logic [PW-1:0] base;
    logic [31:0]   base32;
    logic [31:0]   waddr32;
    logic          outside;
    logic          wr_ok;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
        return (32'(d) > 32'(TEX_MAX_DIM)) ? DW'(TEX_MAX_DIM) : d;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_dim(DW'(256));
            r_height <= clamp_dim(DW'(256));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bts_pkg::CFG_TEX_WIDTH:  r_width  <= clamp_dim(i_cfg_data);
                bts_pkg::CFG_TEX_HEIGHT: r_height <= clamp_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign ix      = i_item.coord_x[15:FRAC_BITS];
    assign iy      = i_item.coord_y[15:FRAC_BITS];
    assign outside = (32'(ix) + 32'd1 >= 32'(r_width)) || (32'(iy) + 32'd1 >= 32'(r_height));
    assign base    = PW'(iy) * PW'(r_width) + PW'(ix);
    assign base32  = 32'(base);
    assign waddr32 = 32'(i_item.texel_addr);
    // writes past the end of the store are dropped here
    assign wr_ok   = (waddr32 < 32'(DEPTH));

    always_comb begin
        o_cmd      = '0;
        o_cmd.data = i_item.texel_data;
        o_cmd.fx   = FW'(i_item.coord_x[FRAC_BITS-1:0]);
        o_cmd.fy   = FW'(i_item.coord_y[FRAC_BITS-1:0]);
        if (i_item.op == bts_pkg::OP_WRITE) begin
            o_cmd.kind = bts_pkg::CMD_WRITE;
            o_cmd.addr = XW'(waddr32[AW-1:0]);
            o_cmd_push = i_accept && wr_ok;
        end else begin
            o_cmd.kind = outside ? bts_pkg::CMD_MISS : bts_pkg::CMD_SAMPLE;
            o_cmd.addr = XW'(base32[AW-1:0]);
            o_cmd_push = i_accept;
        end
    end

    assign o_width = r_width;
endmodule
`default_nettype wire

// File: rtl/bts_back.sv
// back end: texture store, four-tap sequencer and channel blend
`default_nettype none
module bts_back #(
    parameter int TEX_MAX_DIM = 256,
    parameter int FRAC_BITS   = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  bts_pkg::t_cmd               i_cmd,
    input  wire                         i_cmd_empty,
    output logic                        o_cmd_pop,
    input  wire  [bts_pkg::DIM_W-1:0]   i_width,
    output bts_pkg::t_out_item          o_res,
    output logic                        o_res_push,
    input  wire                         i_res_full
);
    localparam int DEPTH = TEX_MAX_DIM * TEX_MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int F     = FRAC_BITS;
    localparam int PRW   = 2 * F + 2;
    localparam int SW    = 2 * F + 10;
    localparam int AC    = bts_pkg::ACC_W;
    localparam logic [F:0]    ONE  = (F + 1)'(1) << F;
    localparam logic [SW-1:0] HALF = SW'(1) << (2 * F - 1);

    logic [31:0]           r_mem [DEPTH];
    logic [31:0]           r_rd_data;

    bts_pkg::t_back_state  r_state, n_state;
    logic [2:0]            r_cnt, n_cnt;
    logic                  r_acc_en, n_acc_en;
    logic [AW-1:0]         r_base, n_base;
    logic [F-1:0]          r_fx, n_fx;
    logic [F-1:0]          r_fy, n_fy;
    logic [PRW-1:0]        r_prod, n_prod;
    logic [3:0][AC-1:0]    r_acc, n_acc;

    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [31:0]           tap32;
    logic [F:0]            wa;
    logic [F:0]            wb;
    logic [SW-1:0]         wsum;
    logic [8:0]            weight;

    function automatic logic [7:0] sat_byte(input logic [AC-1:0] s);
        return (s[AC-1:8] > (AC - 8)'(255)) ? 8'hFF : s[15:8];
    endfunction

    // tap order: top-left, top-right, bottom-left, bottom-right
    assign tap32  = 32'(r_base) + (r_cnt[0] ? 32'd1 : 32'd0)
                  + (r_cnt[1] ? 32'(i_width) : 32'd0);
    assign wa     = r_cnt[0] ? (F + 1)'(r_fx) : ONE - (F + 1)'(r_fx);
    assign wb     = r_cnt[1] ? (F + 1)'(r_fy) : ONE - (F + 1)'(r_fy);
    // weight of the tap issued last cycle, rounded half up
    assign wsum   = {r_prod, 8'b0} + HALF;
    assign weight = wsum[2 * F + 8:2 * F];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bts_pkg::BK_IDLE;
            r_cnt    <= '0;
            r_acc_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_acc_en <= n_acc_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_fx   <= n_fx;
        r_fy   <= n_fy;
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_acc_en   = 1'b0;
        n_base     = r_base;
        n_fx       = r_fx;
        n_fy       = r_fy;
        n_prod     = r_prod;
        n_acc      = r_acc;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = tap32[AW-1:0];
        case (r_state)
            bts_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        bts_pkg::CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_addr  = i_cmd.addr[AW-1:0];
                            o_cmd_pop = 1'b1;
                        end
                        bts_pkg::CMD_MISS: begin
                            if (!i_res_full) begin
                                o_res_push = 1'b1;
                                o_cmd_pop  = 1'b1;
                            end
                        end
                        bts_pkg::CMD_SAMPLE: begin
                            n_base    = i_cmd.addr[AW-1:0];
                            n_fx      = i_cmd.fx[F-1:0];
                            n_fy      = i_cmd.fy[F-1:0];
                            n_acc     = '0;
                            n_cnt     = '0;
                            o_cmd_pop = 1'b1;
                            n_state   = bts_pkg::BK_TAPS;
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            bts_pkg::BK_TAPS: begin
                if (r_acc_en) begin
                    for (int ch = 0; ch < 4; ch++) begin
                        n_acc[ch] = r_acc[ch] + AC'(weight * r_rd_data[8 * ch +: 8]);
                    end
                end
                if (!r_cnt[2]) begin
                    mem_re   = 1'b1;
                    n_prod   = PRW'(wa) * PRW'(wb);
                    n_acc_en = 1'b1;
                    n_cnt    = r_cnt + 3'd1;
                end else begin
                    n_state = bts_pkg::BK_DONE;
                end
            end
            bts_pkg::BK_DONE: begin
                o_res.in_range = 1'b1;
                for (int ch = 0; ch < 4; ch++) begin
                    o_res.sample[8 * ch +: 8] = sat_byte(r_acc[ch]);
                end
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = bts_pkg::BK_IDLE;
                end
            end
            default: n_state = bts_pkg::BK_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/bilinear_texel_sampler.sv
// top level of the bilinear texel sampler
//
// Input channel: push/full with one t_in_item per beat. op write stores
// texel_data at texel_addr; op sample filters the 2x2 texels at coord_x,
// coord_y (unsigned fixed point) and gives one t_out_item on the result
// channel (empty/pop). Writes give no result; writes past the store drop.
// Size registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the
// user must write them only while the block is idle, as the block itself
// does not enforce it; they reset to 256 and clamp to TEX_MAX_DIM.
// A two-entry command queue sits between the front end and the back end.
// The back end reads the single-port texture memory once per tap, so a
// sample passes through one dispatch, four taps plus one drain and one
// result push; a write or an out-of-range sample needs only its dispatch.
// A two-entry result queue holds results while the receiver stalls; when
// it fills the back end waits, then the command queue fills and full rises.
// Reset (synchronous, active low) empties both queues and restores the
// size registers; texture contents are undefined until written.
`default_nettype none
module bilinear_texel_sampler #(
    parameter int TEX_MAX_DIM = 256,
    parameter int FRAC_BITS   = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            push,
    output logic                           full,
    input  bts_pkg::t_in_item              i_in_item,
    output logic                           empty,
    input  wire                            pop,
    output bts_pkg::t_out_item             o_out_item,
    input  wire                            i_cfg_we,
    input  wire  [bts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [bts_pkg::DIM_W-1:0]      i_cfg_data
);
    bts_pkg::t_cmd             cmd_in;
    bts_pkg::t_cmd             cmd_head;
    logic                      cmd_push;
    logic                      cmd_pop;
    logic                      cmd_empty;
    logic                      accept;
    logic [bts_pkg::DIM_W-1:0] width;
    bts_pkg::t_out_item        res_in;
    logic                      res_push;
    logic                      res_full;

    assign accept = push && !full;

    bts_front #(
        .TEX_MAX_DIM (TEX_MAX_DIM),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_accept   (accept),
        .o_cmd      (cmd_in),
        .o_cmd_push (cmd_push),
        .o_width    (width)
    );

    bts_fifo #(
        .T     (bts_pkg::t_cmd),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    bts_back #(
        .TEX_MAX_DIM (TEX_MAX_DIM),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_width     (width),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    bts_fifo #(
        .T     (bts_pkg::t_out_item),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );
endmodule
`default_nettype wire
